FILE: rtl/ecbr_pkg.sv
// shared types, constants and control word encoding for the boundary removal block
package ecbr_pkg;

  // frame store geometry (power-of-two dimensions, address is {row, col})
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_WIDTH  = 256;
  localparam int COORD_W    = 8;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELLS      = MAX_HEIGHT * MAX_WIDTH;
  localparam int DIM_W      = 9;
  localparam int POS_W      = DIM_W;

  // item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MASK     = 2'd2;

  // sweep directions
  localparam logic [1:0] SW_RIGHT = 2'd0;
  localparam logic [1:0] SW_LEFT  = 2'd1;
  localparam logic [1:0] SW_DOWN  = 2'd2;
  localparam logic [1:0] SW_UP    = 2'd3;

  // datapath actions
  localparam int ACT_W = 4;
  localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_RD_ISSUE  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_RD_REPLY  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_SEED_INIT = 4'd4;
  localparam logic [ACT_W-1:0] ACT_SEED      = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SWEEP_INIT = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SWEEP     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_LINE_NEXT = 4'd8;
  localparam logic [ACT_W-1:0] ACT_RUN_DONE  = 4'd9;

  // jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEXT      = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] C_NO_START  = 4'd2;
  localparam logic [COND_W-1:0] C_MODE_LOAD = 4'd3;
  localparam logic [COND_W-1:0] C_MODE_RUN  = 4'd4;
  localparam logic [COND_W-1:0] C_NOT_READ  = 4'd5;
  localparam logic [COND_W-1:0] C_NO_LINES  = 4'd6;
  localparam logic [COND_W-1:0] C_POS_MORE  = 4'd7;
  localparam logic [COND_W-1:0] C_LINE_MORE = 4'd8;
  localparam logic [COND_W-1:0] C_PIX_MORE  = 4'd9;

  // program steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_IDLE       = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP_LOAD  = 5'd1;
  localparam logic [STEP_W-1:0] S_DISP_RUN   = 5'd2;
  localparam logic [STEP_W-1:0] S_DISP_READ  = 5'd3;
  localparam logic [STEP_W-1:0] S_RD_ISSUE   = 5'd4;
  localparam logic [STEP_W-1:0] S_RD_REPLY   = 5'd5;
  localparam logic [STEP_W-1:0] S_LOAD       = 5'd6;
  localparam logic [STEP_W-1:0] S_SEED_INIT  = 5'd7;
  localparam logic [STEP_W-1:0] S_SEED       = 5'd8;
  localparam logic [STEP_W-1:0] S_RIGHT_INIT = 5'd9;
  localparam logic [STEP_W-1:0] S_RIGHT_STEP = 5'd10;
  localparam logic [STEP_W-1:0] S_RIGHT_LINE = 5'd11;
  localparam logic [STEP_W-1:0] S_LEFT_INIT  = 5'd12;
  localparam logic [STEP_W-1:0] S_LEFT_STEP  = 5'd13;
  localparam logic [STEP_W-1:0] S_LEFT_LINE  = 5'd14;
  localparam logic [STEP_W-1:0] S_DOWN_INIT  = 5'd15;
  localparam logic [STEP_W-1:0] S_DOWN_STEP  = 5'd16;
  localparam logic [STEP_W-1:0] S_DOWN_LINE  = 5'd17;
  localparam logic [STEP_W-1:0] S_UP_INIT    = 5'd18;
  localparam logic [STEP_W-1:0] S_UP_STEP    = 5'd19;
  localparam logic [STEP_W-1:0] S_UP_LINE    = 5'd20;
  localparam logic [STEP_W-1:0] S_RUN_DONE   = 5'd21;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               is_boundary;
    logic               under_mask;
  } in_item_t;

  typedef struct packed {
    logic cleaned_pixel;
    logic run_done;
  } out_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [1:0]        sweep;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic mode_load;
    logic mode_run;
    logic mode_read;
    logic no_lines;
    logic pos_more;
    logic line_more;
    logic pix_more;
  } flags_t;

  function automatic ctrl_word_t make_cw(input logic [ACT_W-1:0] act,
                                         input logic [1:0] sweep,
                                         input logic [COND_W-1:0] cond,
                                         input logic [STEP_W-1:0] target);
    ctrl_word_t w;
    w.act    = act;
    w.sweep  = sweep;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

endpackage

FILE: rtl/ecbr_ram.sv
// generic single-write, single-read ram with registered read data
module ecbr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ecbr_sequencer.sv
// microcode sequencer: step counter, control rom and conditional jumps
module ecbr_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ecbr_pkg::flags_t    flags,
  output ecbr_pkg::ctrl_word_t cw,
  output logic                busy
);
  import ecbr_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  // control program
  function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] s);
    ctrl_word_t w;
    case (s)
      S_IDLE:       w = make_cw(ACT_NONE,       SW_RIGHT, C_NO_START,  S_IDLE);
      S_DISP_LOAD:  w = make_cw(ACT_NONE,       SW_RIGHT, C_MODE_LOAD, S_LOAD);
      S_DISP_RUN:   w = make_cw(ACT_NONE,       SW_RIGHT, C_MODE_RUN,  S_SEED_INIT);
      S_DISP_READ:  w = make_cw(ACT_NONE,       SW_RIGHT, C_NOT_READ,  S_IDLE);
      S_RD_ISSUE:   w = make_cw(ACT_RD_ISSUE,   SW_RIGHT, C_NEXT,      S_IDLE);
      S_RD_REPLY:   w = make_cw(ACT_RD_REPLY,   SW_RIGHT, C_ALWAYS,    S_IDLE);
      S_LOAD:       w = make_cw(ACT_LOAD,       SW_RIGHT, C_ALWAYS,    S_IDLE);
      S_SEED_INIT:  w = make_cw(ACT_SEED_INIT,  SW_RIGHT, C_NEXT,      S_IDLE);
      S_SEED:       w = make_cw(ACT_SEED,       SW_RIGHT, C_PIX_MORE,  S_SEED);
      S_RIGHT_INIT: w = make_cw(ACT_SWEEP_INIT, SW_RIGHT, C_NO_LINES,  S_LEFT_INIT);
      S_RIGHT_STEP: w = make_cw(ACT_SWEEP,      SW_RIGHT, C_POS_MORE,  S_RIGHT_STEP);
      S_RIGHT_LINE: w = make_cw(ACT_LINE_NEXT,  SW_RIGHT, C_LINE_MORE, S_RIGHT_STEP);
      S_LEFT_INIT:  w = make_cw(ACT_SWEEP_INIT, SW_LEFT,  C_NO_LINES,  S_DOWN_INIT);
      S_LEFT_STEP:  w = make_cw(ACT_SWEEP,      SW_LEFT,  C_POS_MORE,  S_LEFT_STEP);
      S_LEFT_LINE:  w = make_cw(ACT_LINE_NEXT,  SW_LEFT,  C_LINE_MORE, S_LEFT_STEP);
      S_DOWN_INIT:  w = make_cw(ACT_SWEEP_INIT, SW_DOWN,  C_NO_LINES,  S_UP_INIT);
      S_DOWN_STEP:  w = make_cw(ACT_SWEEP,      SW_DOWN,  C_POS_MORE,  S_DOWN_STEP);
      S_DOWN_LINE:  w = make_cw(ACT_LINE_NEXT,  SW_DOWN,  C_LINE_MORE, S_DOWN_STEP);
      S_UP_INIT:    w = make_cw(ACT_SWEEP_INIT, SW_UP,    C_NO_LINES,  S_RUN_DONE);
      S_UP_STEP:    w = make_cw(ACT_SWEEP,      SW_UP,    C_POS_MORE,  S_UP_STEP);
      S_UP_LINE:    w = make_cw(ACT_LINE_NEXT,  SW_UP,    C_LINE_MORE, S_UP_STEP);
      S_RUN_DONE:   w = make_cw(ACT_RUN_DONE,   SW_RIGHT, C_ALWAYS,    S_IDLE);
      default:      w = make_cw(ACT_NONE,       SW_RIGHT, C_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

  assign cw   = rom_word(step);
  assign busy = (step != S_IDLE);

  // jump condition select
  always_comb begin
    case (cw.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_START:  taken = !start;
      C_MODE_LOAD: taken = flags.mode_load;
      C_MODE_RUN:  taken = flags.mode_run;
      C_NOT_READ:  taken = !flags.mode_read;
      C_NO_LINES:  taken = flags.no_lines;
      C_POS_MORE:  taken = flags.pos_more;
      C_LINE_MORE: taken = flags.line_more;
      C_PIX_MORE:  taken = flags.pix_more;
      default:     taken = 1'b1;
    endcase
  end

  assign step_next = taken ? cw.target : step + STEP_W'(1);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // an accepted item always enters dispatch
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (step == S_DISP_LOAD))
    else $error("accepted item did not enter dispatch");

  // a read reply always follows its issue step
  assert property (@(posedge clk) disable iff (rst)
    (step == S_RD_REPLY) |-> ($past(step) == S_RD_ISSUE))
    else $error("read reply without read issue");

endmodule

FILE: rtl/ecbr_datapath.sv
// pixel stores, scan counters, neighbor window and result register
module ecbr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  ecbr_pkg::in_item_t           item,
  input  ecbr_pkg::ctrl_word_t         cw,
  input  logic [ecbr_pkg::DIM_W-1:0]   frame_h,
  input  logic [ecbr_pkg::DIM_W-1:0]   frame_w,
  input  logic                         use_mask,
  output ecbr_pkg::flags_t             flags,
  output logic                         result_strobe,
  output ecbr_pkg::out_item_t          result
);
  import ecbr_pkg::*;

  in_item_t           item_q;
  logic [COORD_W-1:0] line;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   line_len;
  logic [1:0]         sweep;
  logic               ran;
  logic [DIM_W-1:0]   run_h;
  logic [DIM_W-1:0]   run_w;

  // seed pipeline
  logic               seed_ev;
  logic [ADDR_W-1:0]  seed_addr;
  logic               seed_border;

  // sweep pipeline and window
  logic               sw_active;
  logic               sw_src_ok;
  logic               sw_pix_ok;
  logic [COORD_W-1:0] sw_line;
  logic [COORD_W-1:0] sw_pix;
  logic               win1;
  logic               win2;

  // read item qualifiers
  logic               rd_ok;
  logic               rem_ok;

  // memory ports
  logic               b_we;
  logic [ADDR_W-1:0]  b_waddr;
  logic [ADDR_W-1:0]  b_raddr;
  logic               b_rdata;
  logic               m_rdata;
  logic               r_we;
  logic [ADDR_W-1:0]  r_waddr;
  logic               r_wdata;
  logic [ADDR_W-1:0]  r_raddr;
  logic               r_rdata;

  // decoded scan geometry
  logic               is_col;
  logic               fwd;
  logic               cw_is_col;
  logic [DIM_W-1:0]   outer;
  logic [DIM_W-1:0]   cw_outer;
  logic [COORD_W-1:0] src_line;
  logic [POS_W-1:0]   pos_m1;
  logic [COORD_W-1:0] pix;
  logic [COORD_W-1:0] pos_lo;
  logic [COORD_W-1:0] line_start;
  logic               src_k;
  logic               spread;
  logic               border;
  logic               load_ok;

  assign is_col    = (sweep == SW_RIGHT) || (sweep == SW_LEFT);
  assign fwd       = (sweep == SW_RIGHT) || (sweep == SW_DOWN);
  assign cw_is_col = (cw.sweep == SW_RIGHT) || (cw.sweep == SW_LEFT);
  assign outer     = is_col ? frame_w : frame_h;
  assign cw_outer  = cw_is_col ? frame_w : frame_h;
  assign src_line  = fwd ? line - COORD_W'(1) : line + COORD_W'(1);
  assign pos_m1    = pos - POS_W'(1);
  assign pix       = pos_m1[COORD_W-1:0];
  assign pos_lo    = pos[COORD_W-1:0];
  assign load_ok   = (DIM_W'(item_q.row) < DIM_W'(MAX_HEIGHT)) &&
                     (DIM_W'(item_q.col) < DIM_W'(MAX_WIDTH));

  // first destination line of each sweep
  always_comb begin
    case (cw.sweep)
      SW_RIGHT: line_start = COORD_W'(1);
      SW_LEFT:  line_start = COORD_W'(frame_w - DIM_W'(2));
      SW_DOWN:  line_start = COORD_W'(1);
      SW_UP:    line_start = COORD_W'(frame_h - DIM_W'(2));
      default:  line_start = COORD_W'(1);
    endcase
  end

  // status for the sequencer
  always_comb begin
    flags.mode_load = (item_q.mode == MODE_LOAD);
    flags.mode_run  = (item_q.mode == MODE_RUN);
    flags.mode_read = (item_q.mode == MODE_READ);
    flags.no_lines  = (cw_outer == DIM_W'(1));
    flags.pos_more  = (pos != line_len);
    flags.line_more = fwd ? (DIM_W'(line) != outer - DIM_W'(1)) : (line != '0);
    flags.pix_more  = !((DIM_W'(line) == frame_h - DIM_W'(1)) &&
                        (pos == frame_w - DIM_W'(1)));
  end

  // seed border test on the pixel being issued
  assign border = (line == '0) || (DIM_W'(line) == frame_h - DIM_W'(1)) ||
                  (pos == '0) || (pos == frame_w - DIM_W'(1));

  // read address selection
  always_comb begin
    b_raddr = {item_q.row, item_q.col};
    r_raddr = {item_q.row, item_q.col};
    case (cw.act)
      ACT_SEED: begin
        b_raddr = {line, pos_lo};
      end
      ACT_SWEEP: begin
        b_raddr = is_col ? {pix, line} : {line, pix};
        r_raddr = is_col ? {pos_lo, src_line} : {src_line, pos_lo};
      end
      default: begin
      end
    endcase
  end

  // boundary and mask loads
  assign b_we    = (cw.act == ACT_LOAD) && load_ok;
  assign b_waddr = {item_q.row, item_q.col};

  // removal writes: seed writes every frame pixel, sweeps only set
  assign src_k  = sw_src_ok & r_rdata;
  assign spread = sw_active & sw_pix_ok & b_rdata & (win2 | win1 | src_k);

  always_comb begin
    r_we    = 1'b0;
    r_waddr = seed_addr;
    r_wdata = b_rdata & (seed_border | (use_mask & m_rdata));
    if (seed_ev) begin
      r_we = 1'b1;
    end else if (spread) begin
      r_we    = 1'b1;
      r_waddr = is_col ? {sw_pix, sw_line} : {sw_line, sw_pix};
      r_wdata = 1'b1;
    end
  end

  ecbr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_boundary (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(item_q.is_boundary),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  ecbr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mask (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(item_q.under_mask),
    .raddr(b_raddr), .rdata(m_rdata)
  );

  ecbr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_removal (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  // scan counters, pipeline control and run frame
  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= '0;
      pos       <= '0;
      line_len  <= '0;
      sweep     <= SW_RIGHT;
      ran       <= 1'b0;
      seed_ev   <= 1'b0;
      sw_active <= 1'b0;
      sw_src_ok <= 1'b0;
      sw_pix_ok <= 1'b0;
    end else begin
      seed_ev   <= (cw.act == ACT_SEED);
      sw_active <= (cw.act == ACT_SWEEP);
      sw_src_ok <= (pos != line_len);
      sw_pix_ok <= (pos != '0);
      case (cw.act)
        ACT_SEED_INIT: begin
          line <= '0;
          pos  <= '0;
          ran  <= 1'b1;
        end
        ACT_SEED: begin
          if (pos == frame_w - DIM_W'(1)) begin
            pos  <= '0;
            line <= line + COORD_W'(1);
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        ACT_SWEEP_INIT: begin
          sweep    <= cw.sweep;
          line     <= line_start;
          pos      <= '0;
          line_len <= cw_is_col ? frame_h : frame_w;
        end
        ACT_SWEEP: begin
          pos <= pos + POS_W'(1);
        end
        ACT_LINE_NEXT: begin
          line <= fwd ? line + COORD_W'(1) : line - COORD_W'(1);
          pos  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline payload, window and read qualifiers
  always_ff @(posedge clk) begin
    seed_addr   <= {line, pos_lo};
    seed_border <= border;
    sw_line     <= line;
    sw_pix      <= pix;
    if (sw_active) begin
      win1 <= src_k;
      win2 <= win1;
    end else if ((cw.act == ACT_SWEEP) && (pos == '0)) begin
      win1 <= 1'b0;
      win2 <= 1'b0;
    end
    if (cw.act == ACT_SEED_INIT) begin
      run_h <= frame_h;
      run_w <= frame_w;
    end
    if (cw.act == ACT_RD_ISSUE) begin
      rd_ok  <= (DIM_W'(item_q.row) < frame_h) && (DIM_W'(item_q.col) < frame_w);
      rem_ok <= ran && (DIM_W'(item_q.row) < run_h) && (DIM_W'(item_q.col) < run_w);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cw.act == ACT_RD_REPLY) || (cw.act == ACT_RUN_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_RD_REPLY) begin
      result.cleaned_pixel <= rd_ok & b_rdata & ~(rem_ok & r_rdata);
      result.run_done      <= 1'b0;
    end else if (cw.act == ACT_RUN_DONE) begin
      result.cleaned_pixel <= 1'b0;
      result.run_done      <= 1'b1;
    end
  end

  // seed and sweep evaluation never overlap on the removal write port
  assert property (@(posedge clk) disable iff (rst)
    !(seed_ev && sw_active))
    else $error("seed and sweep writes overlap");

  // a sweep step never issues past the end of its line
  assert property (@(posedge clk) disable iff (rst)
    (cw.act == ACT_SWEEP) |-> (pos <= line_len))
    else $error("sweep position beyond line length");

endmodule

FILE: rtl/edge_connected_boundary_removal_unit.sv
// top level: configuration registers, sequencer and datapath
//
// One item at a time. A read has its result strobed in the cycle in which
// busy falls, and a run on an H by W frame has its run_done result strobed
// in the cycle in which busy falls. The removal memory has one read and one
// write port: the seed pass and each of the four spreading sweeps visit one
// pixel per cycle, and each sweep line adds a step that drains the neighbor
// window and a step that moves to the next line. Results are shown for one
// cycle on result_strobe and cannot be held off. The removal map needs no
// clearing pass: the seed pass rewrites every pixel of the run frame, and
// pixels outside the last run frame read as not removed.
module edge_connected_boundary_removal_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ecbr_pkg::in_item_t                 item,
  output logic                               result_strobe,
  output ecbr_pkg::out_item_t                result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ecbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecbr_pkg::DIM_W-1:0]         cfg_data
);
  import ecbr_pkg::*;

  logic [DIM_W-1:0] frame_height;
  logic [DIM_W-1:0] frame_width;
  logic             use_mask;
  logic [DIM_W-1:0] frame_h;
  logic [DIM_W-1:0] frame_w;
  logic             accept;
  ctrl_word_t       cw;
  flags_t           flags;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_height <= DIM_W'(256);
      frame_width  <= DIM_W'(256);
      use_mask     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_USE_MASK:     use_mask     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // frame size limited to 1..max
  always_comb begin
    if (frame_height == '0) begin
      frame_h = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      frame_h = DIM_W'(MAX_HEIGHT);
    end else begin
      frame_h = frame_height;
    end
    if (frame_width == '0) begin
      frame_w = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      frame_w = DIM_W'(MAX_WIDTH);
    end else begin
      frame_w = frame_width;
    end
  end

  ecbr_sequencer u_seq (
    .clk(clk), .rst(rst), .start(start), .flags(flags), .cw(cw), .busy(busy)
  );

  ecbr_datapath u_dp (
    .clk(clk), .rst(rst), .accept(accept), .item(item), .cw(cw),
    .frame_h(frame_h), .frame_w(frame_w), .use_mask(use_mask),
    .flags(flags), .result_strobe(result_strobe), .result(result)
  );

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block idle right after accepting an item");

endmodule

FILE: sim/ecbr_result_checker.sv
// result checker for the boundary removal block: predicts every answer and compares
`timescale 1ns / 1ps

module ecbr_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  ecbr_pkg::in_item_t             item,
  input  logic                           result_strobe,
  input  ecbr_pkg::out_item_t            result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ecbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecbr_pkg::DIM_W-1:0]     cfg_data,
  output int                             errors,
  output int                             outstanding
);

  import ecbr_pkg::*;

  // predictor copy of the stores and registers
  bit boundary_map [CELLS];
  bit mask_map [CELLS];
  bit removed_map [CELLS];
  logic [DIM_W-1:0] frame_rows;
  logic [DIM_W-1:0] frame_cols;
  logic             mask_enable;

  // answers still owed by the block, oldest first
  out_item_t answer_q [$];

  function automatic int unsigned addr(int unsigned r, int unsigned c);
    return r * MAX_WIDTH + c;
  endfunction

  // zero counts as one, anything past the store counts as the store size
  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // copy removal into column c from column src, rows r-1..r+1
  task automatic spread_column(int unsigned h, int unsigned c, int unsigned src);
    int unsigned r;
    for (r = 0; r < h; r++) begin
      if (boundary_map[addr(r, c)] &&
          (removed_map[addr(r, src)] ||
           (r > 0 && removed_map[addr(r - 1, src)]) ||
           (r + 1 < h && removed_map[addr(r + 1, src)])))
        removed_map[addr(r, c)] = 1'b1;
    end
  endtask

  // copy removal into row r from row src, columns c-1..c+1
  task automatic spread_row(int unsigned w, int unsigned r, int unsigned src);
    int unsigned c;
    for (c = 0; c < w; c++) begin
      if (boundary_map[addr(r, c)] &&
          (removed_map[addr(src, c)] ||
           (c > 0 && removed_map[addr(src, c - 1)]) ||
           (c + 1 < w && removed_map[addr(src, c + 1)])))
        removed_map[addr(r, c)] = 1'b1;
    end
  endtask

  // seed from border and mask, then right, left, down and up sweeps
  task automatic rebuild_removal_map();
    int unsigned h, w, r, c, k;
    h = clamp_dim(frame_rows, MAX_HEIGHT);
    w = clamp_dim(frame_cols, MAX_WIDTH);
    for (k = 0; k < CELLS; k++) removed_map[k] = 1'b0;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        k = addr(r, c);
        if (boundary_map[k] &&
            (r == 0 || r == h - 1 || c == 0 || c == w - 1 || (mask_enable && mask_map[k])))
          removed_map[k] = 1'b1;
      end
    end
    for (c = 1; c < w; c++) spread_column(h, c, c - 1);
    for (c = w - 1; c > 0; c--) spread_column(h, c - 1, c);
    for (r = 1; r < h; r++) spread_row(w, r, r - 1);
    for (r = h - 1; r > 0; r--) spread_row(w, r - 1, r);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    int unsigned k;
    if (rst) begin
      frame_rows  = 9'd256;
      frame_cols  = 9'd256;
      mask_enable = 1'b0;
      answer_q.delete();
      for (k = 0; k < CELLS; k++) removed_map[k] = 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_HEIGHT: frame_rows  = cfg_data;
          REG_FRAME_WIDTH:  frame_cols  = cfg_data;
          REG_USE_MASK:     mask_enable = cfg_data[0];
          default: ;
        endcase
      end
      // results against the oldest answer owed
      if (result_strobe) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result %b with no answer pending", result));
        end else begin
          want = answer_q.pop_front();
          if (result.run_done !== want.run_done)
            report_mismatch($sformatf("run_done %b, expected %b",
                                      result.run_done, want.run_done));
          if (result.cleaned_pixel !== want.cleaned_pixel)
            report_mismatch($sformatf("cleaned_pixel %b, expected %b (run_done %b)",
                                      result.cleaned_pixel, want.cleaned_pixel,
                                      want.run_done));
        end
      end
      // accepted items; every row and column fits the store, so no load is dropped
      if (start && !busy) begin
        k = addr(item.row, item.col);
        case (item.mode)
          MODE_LOAD: begin
            boundary_map[k] = item.is_boundary;
            mask_map[k]     = item.under_mask;
          end
          MODE_RUN: begin
            rebuild_removal_map();
            want.cleaned_pixel = 1'b0;
            want.run_done      = 1'b1;
            answer_q.push_back(want);
          end
          MODE_READ: begin
            want.run_done = 1'b0;
            if (item.row < clamp_dim(frame_rows, MAX_HEIGHT) &&
                item.col < clamp_dim(frame_cols, MAX_WIDTH))
              want.cleaned_pixel = boundary_map[k] & ~removed_map[k];
            else
              want.cleaned_pixel = 1'b0;
            answer_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    outstanding = answer_q.size();
  end

endmodule

FILE: sim/tb_edge_connected_boundary_removal_unit.sv
// testbench top for the boundary removal block: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_edge_connected_boundary_removal_unit;

  import ecbr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 1850;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int LIMIT_NS      = 8_000_000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             item;
  logic                 result_strobe;
  out_item_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  int                   errors;
  int                   outstanding;

  // pixels written so far, so that nothing unwritten is ever read or swept
  bit          loaded_map [CELLS];
  int unsigned loaded_list [$];
  int unsigned items_sent = 0;
  int unsigned calm_left = 0;

  edge_connected_boundary_removal_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ecbr_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // mostly short gaps, a few long ones, and runs of back-to-back items
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned long_dim();
    case ($urandom_range(0, 3))
      0:       return 255;
      1:       return 256;
      2:       return 511;
      default: return $urandom_range(257, 510);
    endcase
  endfunction

  function automatic int unsigned short_dim();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  // hold start with the item until the block takes it
  task automatic send_item(logic [1:0] mode, int unsigned row, int unsigned col,
                           bit bnd, bit msk);
    in_item_t    it;
    int unsigned gap;
    it.mode        = mode;
    it.row         = COORD_W'(row);
    it.col         = COORD_W'(col);
    it.is_boundary = bnd;
    it.under_mask  = msk;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic load_pixel(int unsigned row, int unsigned col, bit bnd, bit msk);
    int unsigned k;
    k = row * MAX_WIDTH + col;
    send_item(MODE_LOAD, row, col, bnd, msk);
    if (!loaded_map[k]) begin
      loaded_map[k] = 1'b1;
      loaded_list.push_back(k);
    end
  endtask

  task automatic read_pixel(int unsigned row, int unsigned col);
    send_item(MODE_READ, row, col, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic read_any_loaded();
    int unsigned k;
    k = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    read_pixel(k / MAX_WIDTH, k % MAX_WIDTH);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers change only once the block has gone quiet
  task automatic configure(int unsigned h_cfg, int unsigned w_cfg, bit mask_sel);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_FRAME_HEIGHT, DIM_W'(h_cfg));
    write_reg(REG_FRAME_WIDTH, DIM_W'(w_cfg));
    write_reg(REG_USE_MASK, DIM_W'(mask_sel));
    cfg_valid <= 1'b0;
  endtask

  // one frame setting: fresh content, run, reads, touch-ups, maybe a second run
  task automatic run_phase(int unsigned h_cfg, int unsigned w_cfg, bit mask_sel);
    int unsigned h, w, density, mask_pct, r, c;
    bit island, on_border, bnd;
    configure(h_cfg, w_cfg, mask_sel);
    h = (h_cfg == 0) ? 1 : ((h_cfg > MAX_HEIGHT) ? MAX_HEIGHT : h_cfg);
    w = (w_cfg == 0) ? 1 : ((w_cfg > MAX_WIDTH) ? MAX_WIDTH : w_cfg);
    density  = $urandom_range(30, 85);
    mask_pct = $urandom_range(0, 15);
    island   = $urandom_range(0, 1);
    // island frames keep the border mostly clear so interior contours survive
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        on_border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
        bnd = ($urandom_range(0, 99) < density);
        if (island && on_border && $urandom_range(0, 9) != 0) bnd = 1'b0;
        load_pixel(r, c, bnd, $urandom_range(0, 99) < mask_pct);
      end
    end
    // stray loads anywhere in the store
    repeat ($urandom_range(1, 3))
      load_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0)
      send_item(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 1), $urandom_range(0, 1));
    send_item(MODE_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 1), $urandom_range(0, 1));
    repeat ($urandom_range(8, 24)) read_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1));
    repeat ($urandom_range(1, 4)) read_any_loaded();
    // loads after a run change the boundary bit but not the removal map
    repeat ($urandom_range(0, 4))
      load_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
    repeat ($urandom_range(1, 6)) read_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1));
    if ($urandom_range(0, 1) == 1) begin
      send_item(MODE_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 1), $urandom_range(0, 1));
      repeat ($urandom_range(4, 12))
        read_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned phase, h_cfg, w_cfg;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // before any run a read returns the loaded boundary bit
    load_pixel(0, 0, 1'b1, 1'b0);
    load_pixel(255, 255, 1'b1, 1'b1);
    load_pixel(170, 85, 1'b1, 1'b0);
    load_pixel(85, 170, 1'b0, 1'b1);
    load_pixel(0, 255, 1'b1, 1'b1);
    load_pixel(255, 0, 1'b0, 1'b0);
    read_pixel(0, 0);
    read_pixel(255, 255);
    read_pixel(170, 85);
    read_pixel(85, 170);
    read_pixel(0, 255);
    read_pixel(255, 0);
    // unused mode leaves the store alone
    send_item(MODE_UNUSED, 255, 255, 1'b0, 1'b0);
    read_pixel(255, 255);

    // zero sizes give a one-pixel frame; reads outside it return zero
    configure(0, 0, 1'b1);
    send_item(MODE_RUN, 0, 0, 1'b0, 1'b0);
    read_pixel(0, 0);
    read_pixel(255, 255);
    read_pixel(170, 85);
    read_pixel(0, 255);

    // random phases, with long thin frames and one medium frame among them
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        1: begin
          h_cfg = long_dim();
          w_cfg = $urandom_range(0, 2);
        end
        3: begin
          h_cfg = $urandom_range(0, 2);
          w_cfg = long_dim();
        end
        5: begin
          h_cfg = $urandom_range(16, 24);
          w_cfg = $urandom_range(16, 24);
        end
        default: begin
          h_cfg = short_dim();
          w_cfg = short_dim();
        end
      endcase
      run_phase(h_cfg, w_cfg, $urandom_range(0, 1));
      phase++;
    end

    // drain and settle
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #LIMIT_NS;
    $display("run timed out");
    $display("FAILURE");
    $finish;
  end

endmodule
